// ===== rtl/isrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Insertion sorter package
// Shared constants and types for the cell chain and its controller.
// ----------------------------------------------------------------------------
package isrt_pkg;

    localparam int DEPTH = 32;
    localparam int KEY_W = 32;

    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic load;
        logic drain;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== rtl/isrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Insertion sorter cell
// Holds one key of the sorted list. On a load it either keeps its key, takes
// its lower neighbor's key or takes the new key; on a drain it takes its upper
// neighbor's key so the list moves toward the output.
// ----------------------------------------------------------------------------
module isrt_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire isrt_pkg::t_cell_ctrl i_ctrl,
    input  wire isrt_pkg::t_key     i_key,
    input  wire                     i_prev_valid,
    input  wire                     i_prev_gt,
    input  wire isrt_pkg::t_key     i_prev_key,
    input  wire                     i_next_valid,
    input  wire isrt_pkg::t_key     i_next_key,
    output logic                    o_valid,
    output logic                    o_gt,
    output isrt_pkg::t_key          o_key
);
    import isrt_pkg::*;

    logic r_valid;
    logic n_valid;
    t_key r_key;
    t_key n_key;

    // Strict compare keeps equal keys in arrival order.
    assign o_gt    = r_valid && (r_key > i_key);
    assign o_valid = r_valid;
    assign o_key   = r_key;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        priority if (i_ctrl.drain) begin
            n_valid = i_next_valid;
            n_key   = i_next_key;
        end else if (i_ctrl.load && i_prev_gt) begin
            n_valid = 1'b1;
            n_key   = i_prev_key;
        end else if (i_ctrl.load && i_prev_valid && (o_gt || !r_valid)) begin
            n_valid = 1'b1;
            n_key   = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
`default_nettype wire

// ===== rtl/insertion_sorter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Insertion sorter
// Sorts a list of unsigned keys in a chain of compare-and-shift cells and
// emits it in ascending order after the key marked last.
// ----------------------------------------------------------------------------
// Loading: one key per cycle while busy is low; every cell compares against
// the new key at once. After the last key is taken, results follow from the
// next cycle on, one per cycle from the head cell; busy is high while they
// are emitted and the chain is empty again when the final result goes.
// The receiver cannot stall. Synchronous active-low reset empties the chain.
module insertion_sorter (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire isrt_pkg::t_key i_key_in,
    input  wire                 i_last_in,
    output logic                o_valid,
    output isrt_pkg::t_key      o_key_out,
    output logic                o_last_out,
    output logic                o_dropped
);
    import isrt_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic       r_overflow;
    logic       n_overflow;
    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_full;
    logic       w_final;

    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_gt;
    t_key             w_key      [DEPTH];
    logic [DEPTH-1:0] w_prev_valid;
    logic [DEPTH-1:0] w_prev_gt;
    t_key             w_prev_key [DEPTH];
    logic [DEPTH-1:0] w_next_valid;
    t_key             w_next_key [DEPTH];

    assign w_accept = start && !busy;
    assign w_full   = w_valid[DEPTH-1];
    assign w_final  = (r_state == ST_DRAIN) && !w_valid[1];

    // Neighbor wiring: the head cell sees an always-valid, never-greater
    // neighbor below it, and the tail cell drains in an empty slot.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                w_prev_valid[i] = 1'b1;
                w_prev_gt[i]    = 1'b0;
                w_prev_key[i]   = '0;
            end else begin
                w_prev_valid[i] = w_valid[i-1];
                w_prev_gt[i]    = w_gt[i-1];
                w_prev_key[i]   = w_key[i-1];
            end
            if (i == DEPTH-1) begin
                w_next_valid[i] = 1'b0;
                w_next_key[i]   = '0;
            end else begin
                w_next_valid[i] = w_valid[i+1];
                w_next_key[i]   = w_key[i+1];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        isrt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_key        (i_key_in),
            .i_prev_valid (w_prev_valid[g]),
            .i_prev_gt    (w_prev_gt[g]),
            .i_prev_key   (w_prev_key[g]),
            .i_next_valid (w_next_valid[g]),
            .i_next_key   (w_next_key[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g]),
            .o_key        (w_key[g])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept && i_last_in) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_final) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Outputs and cell control.
    always_comb begin
        busy         = 1'b0;
        o_valid      = 1'b0;
        w_ctrl.load  = 1'b0;
        w_ctrl.drain = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                // A key that finds the chain full is dropped.
                w_ctrl.load = w_accept && !w_full;
            end
            ST_DRAIN: begin
                busy         = 1'b1;
                o_valid      = 1'b1;
                w_ctrl.drain = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    assign o_key_out  = w_key[0];
    assign o_last_out = o_valid && !w_valid[1];
    assign o_dropped  = r_overflow;

    always_comb begin
        n_overflow = r_overflow;
        priority if (w_accept && w_full) begin
            n_overflow = 1'b1;
        end else if (w_final) begin
            n_overflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

    // The occupied cells always form an unbroken run from the head.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("occupied cells are not contiguous");

    a_strobe_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_valid[0])
        else $error("result strobed from an empty head cell");

    a_empty_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |=> (w_valid == '0) && !r_overflow)
        else $error("chain not emptied after the final transfer");

    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full) |=> r_overflow && $stable(w_valid))
        else $error("dropped key changed the chain or missed the flag");

endmodule
`default_nettype wire
